@@ rtl/shader_integer_ext_alu_core_assert.svh @@
// Assertion macros used by the bound checker module.
`ifndef SHADER_INTEGER_EXT_ALU_CORE_ASSERT_SVH
`define SHADER_INTEGER_EXT_ALU_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SIEXT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SIEXT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/siext_pkg.sv @@
package siext_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 5;
    localparam int OP_W   = 4;

    localparam logic [DATA_W-1:0] NONE_FOUND = '1;
    localparam logic [DATA_W-1:0] SIGN_BIT   = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_SABS   = 4'd0,
        OP_SSIGN  = 4'd1,
        OP_UMIN   = 4'd2,
        OP_UMAX   = 4'd3,
        OP_SMIN   = 4'd4,
        OP_SMAX   = 4'd5,
        OP_UCLAMP = 4'd6,
        OP_SCLAMP = 4'd7,
        OP_LSB    = 4'd8,
        OP_SMSB   = 4'd9,
        OP_UMSB   = 4'd10
    } op_t;

    // Orderings among the three operands; y_lt_x means y < x.
    typedef struct packed {
        logic y_lt_x;
        logic z_lt_x;
        logic z_lt_y;
    } cmp_flags_t;

    // Index of the highest set bit by halving search (bit 31 wins).
    function automatic logic [IDX_W-1:0] msb_index(input logic [DATA_W-1:0] v);
        logic [IDX_W-1:0] idx;
        logic [15:0] v16;
        logic [7:0]  v8;
        logic [3:0]  v4;
        logic [1:0]  v2;
        idx[4] = |v[31:16];
        v16    = idx[4] ? v[31:16] : v[15:0];
        idx[3] = |v16[15:8];
        v8     = idx[3] ? v16[15:8] : v16[7:0];
        idx[2] = |v8[7:4];
        v4     = idx[2] ? v8[7:4] : v8[3:0];
        idx[1] = |v4[3:2];
        v2     = idx[1] ? v4[3:2] : v4[1:0];
        idx[0] = v2[1];
        return idx;
    endfunction

    // Index of the lowest set bit by halving search (bit 0 wins).
    function automatic logic [IDX_W-1:0] lsb_index(input logic [DATA_W-1:0] v);
        logic [IDX_W-1:0] idx;
        logic [15:0] v16;
        logic [7:0]  v8;
        logic [3:0]  v4;
        logic [1:0]  v2;
        idx[4] = ~(|v[15:0]);
        v16    = idx[4] ? v[31:16] : v[15:0];
        idx[3] = ~(|v16[7:0]);
        v8     = idx[3] ? v16[15:8] : v16[7:0];
        idx[2] = ~(|v8[3:0]);
        v4     = idx[2] ? v8[7:4] : v8[3:0];
        idx[1] = ~(|v4[1:0]);
        v2     = idx[1] ? v4[3:2] : v4[1:0];
        idx[0] = ~v2[0];
        return idx;
    endfunction

endpackage

@@ rtl/siext_if.sv @@
interface siext_req_if;
    logic                                valid;
    logic                                ready;
    logic [siext_pkg::OP_W-1:0]          req_type;
    logic [siext_pkg::DATA_W-1:0]        operand_x;
    logic [siext_pkg::DATA_W-1:0]        operand_y;
    logic [siext_pkg::DATA_W-1:0]        operand_z;

    modport source (output valid, req_type, operand_x, operand_y, operand_z, input ready);
    modport sink   (input valid, req_type, operand_x, operand_y, operand_z, output ready);
endinterface

interface siext_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [siext_pkg::DATA_W-1:0]        result_bits;

    modport source (output valid, result_bits, input ready);
    modport sink   (input valid, result_bits, output ready);
endinterface

@@ rtl/siext_cmp.sv @@
module siext_cmp (
    input  logic [siext_pkg::DATA_W-1:0] x,
    input  logic [siext_pkg::DATA_W-1:0] y,
    input  logic [siext_pkg::DATA_W-1:0] z,
    input  logic                         is_signed,
    output siext_pkg::cmp_flags_t        flags
);

    logic [siext_pkg::DATA_W-1:0] bias;
    logic [siext_pkg::DATA_W-1:0] xb;
    logic [siext_pkg::DATA_W-1:0] yb;
    logic [siext_pkg::DATA_W-1:0] zb;

    // Flip the sign bit so one unsigned compare serves both orderings.
    assign bias = is_signed ? siext_pkg::SIGN_BIT : '0;
    assign xb   = x ^ bias;
    assign yb   = y ^ bias;
    assign zb   = z ^ bias;

    assign flags.y_lt_x = (yb < xb);
    assign flags.z_lt_x = (zb < xb);
    assign flags.z_lt_y = (zb < yb);

endmodule

@@ rtl/siext_exec.sv @@
module siext_exec (
    input  logic [siext_pkg::OP_W-1:0]   req_type,
    input  logic [siext_pkg::DATA_W-1:0] x,
    input  logic [siext_pkg::DATA_W-1:0] y,
    input  logic [siext_pkg::DATA_W-1:0] z,
    output logic [siext_pkg::DATA_W-1:0] result
);

    siext_pkg::op_t               op;
    siext_pkg::cmp_flags_t        flags;
    logic                         is_signed;
    logic [siext_pkg::DATA_W-1:0] min_xy;
    logic [siext_pkg::DATA_W-1:0] max_xy;
    logic                         z_lt_max;
    logic [siext_pkg::DATA_W-1:0] clamp_val;
    logic [siext_pkg::DATA_W-1:0] smsb_src;
    logic [siext_pkg::DATA_W-1:0] pad_lsb;
    logic [siext_pkg::DATA_W-1:0] pad_msb;
    logic [siext_pkg::DATA_W-1:0] pad_smsb;

    assign op = siext_pkg::op_t'(req_type);

    assign is_signed = (op == siext_pkg::OP_SMIN) || (op == siext_pkg::OP_SMAX) ||
                       (op == siext_pkg::OP_SCLAMP);

    siext_cmp u_cmp (
        .x         (x),
        .y         (y),
        .z         (z),
        .is_signed (is_signed),
        .flags     (flags)
    );

    // Clamp reuses the parallel compares: pick z against whichever of x, y is larger.
    assign min_xy    = flags.y_lt_x ? y : x;
    assign max_xy    = flags.y_lt_x ? x : y;
    assign z_lt_max  = flags.y_lt_x ? flags.z_lt_x : flags.z_lt_y;
    assign clamp_val = z_lt_max ? z : max_xy;

    assign smsb_src = x[siext_pkg::DATA_W-1] ? ~x : x;
    assign pad_lsb  = {{(siext_pkg::DATA_W-siext_pkg::IDX_W){1'b0}},
                       siext_pkg::lsb_index(x)};
    assign pad_msb  = {{(siext_pkg::DATA_W-siext_pkg::IDX_W){1'b0}},
                       siext_pkg::msb_index(x)};
    assign pad_smsb = {{(siext_pkg::DATA_W-siext_pkg::IDX_W){1'b0}},
                       siext_pkg::msb_index(smsb_src)};

    always_comb
    begin
        unique case (op)
            siext_pkg::OP_SABS:
            begin
                result = x[siext_pkg::DATA_W-1] ? ('0 - x) : x;
            end
            siext_pkg::OP_SSIGN:
            begin
                if (x == '0)
                    result = '0;
                else if (x[siext_pkg::DATA_W-1])
                    result = '1;
                else
                    result = {{(siext_pkg::DATA_W-1){1'b0}}, 1'b1};
            end
            siext_pkg::OP_UMIN, siext_pkg::OP_SMIN:
            begin
                result = min_xy;
            end
            siext_pkg::OP_UMAX, siext_pkg::OP_SMAX:
            begin
                result = max_xy;
            end
            siext_pkg::OP_UCLAMP, siext_pkg::OP_SCLAMP:
            begin
                result = clamp_val;
            end
            siext_pkg::OP_LSB:
            begin
                result = (x == '0) ? siext_pkg::NONE_FOUND : pad_lsb;
            end
            siext_pkg::OP_SMSB:
            begin
                result = (smsb_src == '0) ? siext_pkg::NONE_FOUND : pad_smsb;
            end
            siext_pkg::OP_UMSB:
            begin
                result = (x == '0) ? siext_pkg::NONE_FOUND : pad_msb;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

@@ rtl/shader_integer_ext_alu_core.sv @@
// Integer extended-instruction ALU, one 32-bit component per beat.
//
// Channels: req carries an opcode (req_type) and up to three operands;
// rsp returns one result_bits beat for every req beat, in order. Both use
// valid/ready; a beat moves on a rising edge with valid and ready high.
//
// Pipeline: the req beat is captured in an input register, the opcode logic
// runs on it combinationally, and the answer lands in the result register,
// which drives rsp; a stall can hold the beat in either register.
// Throughput: one beat per cycle while rsp.ready stays high, as the opcode
// logic between the input register and the result register is combinational.
//
// Stall: when rsp.ready is low with a result waiting, the result register
// holds and the input register holds behind it; req.ready drops only when
// both are full. No beat is lost or repeated.
//
// Reset: rst_n clears both valid flags asynchronously; the payload registers
// are not reset, and req.ready is high right after reset.
module shader_integer_ext_alu_core (
    input  logic          clk,
    input  logic          rst_n,
    siext_req_if.sink     req,
    siext_rsp_if.source   rsp
);

    // Input register stage.
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic [siext_pkg::OP_W-1:0]   s1_op_reg;
    logic [siext_pkg::DATA_W-1:0] s1_x_reg;
    logic [siext_pkg::DATA_W-1:0] s1_y_reg;
    logic [siext_pkg::DATA_W-1:0] s1_z_reg;

    // Result register stage.
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [siext_pkg::DATA_W-1:0] out_result_reg;

    logic                         out_load;
    logic                         s1_load;
    logic [siext_pkg::DATA_W-1:0] exec_result;

    // Advance the result register when it is empty or being drained.
    assign out_load = !out_valid_reg || rsp.ready;
    // Take a new beat when the input register is empty or moving forward.
    assign req.ready = !s1_valid_reg || out_load;
    assign s1_load   = req.valid && req.ready;

    siext_exec u_exec (
        .req_type (s1_op_reg),
        .x        (s1_x_reg),
        .y        (s1_y_reg),
        .z        (s1_z_reg),
        .result   (exec_result)
    );

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (req.ready)
            s1_valid_next = req.valid;
        if (out_load)
            out_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: capture on load, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_op_reg <= req.req_type;
            s1_x_reg  <= req.operand_x;
            s1_y_reg  <= req.operand_y;
            s1_z_reg  <= req.operand_z;
        end
        if (out_load && s1_valid_reg)
            out_result_reg <= exec_result;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_bits = out_result_reg;

endmodule

@@ rtl/shader_integer_ext_alu_core_chk.sv @@
`include "shader_integer_ext_alu_core_assert.svh"

module shader_integer_ext_alu_core_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [siext_pkg::DATA_W-1:0] rsp_result_bits
);

    logic req_beat;
    logic rsp_free;
    logic rsp_stall;
    logic idle_free;

    assign req_beat  = req_valid && req_ready;
    assign rsp_free  = !rsp_valid || rsp_ready;
    assign rsp_stall = rsp_valid && !rsp_ready;
    assign idle_free = !req_beat && rsp_free;

    `SIEXT_ASSERT_NEXT(a_rsp_hold_valid, clk, rst_n, rsp_stall, rsp_valid, "rsp valid dropped")

    `SIEXT_ASSERT_NEXT(a_rsp_hold_data, clk, rst_n, rsp_stall, $stable(rsp_result_bits), "rsp data moved")

    `SIEXT_ASSERT_NOW(a_ready_when_free, clk, rst_n, rsp_free, req_ready, "req not ready")

    `SIEXT_ASSERT_NEXT(a_drain_empty, clk, rst_n, idle_free ##1 idle_free, !rsp_valid, "rsp valid when empty")

endmodule

bind shader_integer_ext_alu_core shader_integer_ext_alu_core_chk u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_result_bits (rsp.result_bits)
);

@@ verif/shader_integer_ext_alu_core_checker.sv @@
`timescale 1ns / 100ps
module shader_integer_ext_alu_core_checker (
    input  logic clk,
    input  logic rst_n,
    siext_req_if req,
    siext_rsp_if rsp,
    output int   mismatch_count,
    output int   outstanding
);

    typedef struct {
        logic [siext_pkg::OP_W-1:0]   opcode;
        logic [siext_pkg::DATA_W-1:0] x;
        logic [siext_pkg::DATA_W-1:0] result;
    } expected_t;

    expected_t pending_results[$];

    // Highest (from_top) or lowest set bit index; all ones when none is set.
    function automatic logic [siext_pkg::DATA_W-1:0] bit_scan(
        input logic [siext_pkg::DATA_W-1:0] v,
        input bit                           from_top);
        logic [siext_pkg::DATA_W-1:0] idx;
        idx = siext_pkg::NONE_FOUND;
        for (int i = 0; i < siext_pkg::DATA_W; i++) begin
            if (v[i] && (from_top || idx == siext_pkg::NONE_FOUND))
                idx = i;
        end
        return idx;
    endfunction

    function automatic logic [siext_pkg::DATA_W-1:0] ext_int_result(
        input logic [siext_pkg::OP_W-1:0]   opcode,
        input logic [siext_pkg::DATA_W-1:0] x,
        input logic [siext_pkg::DATA_W-1:0] y,
        input logic [siext_pkg::DATA_W-1:0] z);
        logic [siext_pkg::DATA_W-1:0] r;
        logic [siext_pkg::DATA_W-1:0] lo_bound;
        r = '0;
        lo_bound = '0;
        case (opcode)
            siext_pkg::OP_SABS:
                r = x[siext_pkg::DATA_W-1] ? ({siext_pkg::DATA_W{1'b0}} - x) : x;
            siext_pkg::OP_SSIGN:
                r = (x == '0) ? '0 : (x[siext_pkg::DATA_W-1] ? '1 : 1);
            siext_pkg::OP_UMIN:   r = (y < x) ? y : x;
            siext_pkg::OP_UMAX:   r = (x < y) ? y : x;
            siext_pkg::OP_SMIN:   r = ($signed(y) < $signed(x)) ? y : x;
            siext_pkg::OP_SMAX:   r = ($signed(x) < $signed(y)) ? y : x;
            siext_pkg::OP_UCLAMP:
            begin
                lo_bound = (x < y) ? y : x;
                r = (z < lo_bound) ? z : lo_bound;
            end
            siext_pkg::OP_SCLAMP:
            begin
                lo_bound = ($signed(x) < $signed(y)) ? y : x;
                r = ($signed(z) < $signed(lo_bound)) ? z : lo_bound;
            end
            siext_pkg::OP_LSB:    r = bit_scan(x, 1'b0);
            // negative values count on their one's complement
            siext_pkg::OP_SMSB:   r = bit_scan(x[siext_pkg::DATA_W-1] ? ~x : x, 1'b1);
            siext_pkg::OP_UMSB:   r = bit_scan(x, 1'b1);
            default:              r = '0;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin : monitor
        expected_t head;
        expected_t item;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: expected none, got %h",
                             $time, rsp.result_bits);
                    mismatch_count++;
                end
                else
                begin
                    head = pending_results.pop_front();
                    if (head.result !== rsp.result_bits)
                    begin
                        $display("%0t: result_bits mismatch op %0d x %h: expected %h, got %h",
                                 $time, head.opcode, head.x, head.result, rsp.result_bits);
                        mismatch_count++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                item.opcode = req.req_type;
                item.x      = req.operand_x;
                item.result = ext_int_result(req.req_type, req.operand_x,
                                             req.operand_y, req.operand_z);
                pending_results.insert(pending_results.size(), item);
            end
            outstanding = pending_results.size();
        end
    end

endmodule

@@ verif/shader_integer_ext_alu_core_tb.sv @@
`timescale 1ns / 100ps
module shader_integer_ext_alu_core_tb;

    // Opcodes past the last defined one; the block must answer them with zero.
    localparam logic [siext_pkg::OP_W-1:0] OP_SPARE_LO = 4'd11;
    localparam logic [siext_pkg::OP_W-1:0] OP_SPARE_HI = 4'd15;

    localparam int IDLE_PCT     = 21;   // chance of a bubble on either side
    localparam int HOLD_CYCLES  = 200;  // long result back-pressure
    localparam int STALL_LIMIT  = 2000; // cycles without any beat before giving up
    localparam int DRAIN_CYCLES = 10;   // tail after the last result

    logic clk;
    logic rst_n;
    bit   steady;        // set: no bubbles on either side
    int   hold_count;    // bumped by stimulus to ask the result side for a long hold
    int   mismatch_count;
    int   outstanding;

    siext_req_if req_ch ();
    siext_rsp_if rsp_ch ();

    shader_integer_ext_alu_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    shader_integer_ext_alu_core_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Operand mix: full random, small magnitudes on both sides of zero, single bits,
    // right-shifted patterns and their inverses for the bit scans, and the sign boundary.
    function automatic logic [siext_pkg::DATA_W-1:0] pick_operand();
        logic [siext_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 6))
            0: v = $urandom();
            1: v = $urandom_range(0, 8);
            2: v = {siext_pkg::DATA_W{1'b0}} - $urandom_range(1, 8);
            3: v = 1 << $urandom_range(0, siext_pkg::DATA_W - 1);
            4: v = $urandom() >> $urandom_range(0, siext_pkg::DATA_W - 1);
            5: v = ~($urandom() >> $urandom_range(0, siext_pkg::DATA_W - 1));
            default:
            begin
                case ($urandom_range(0, 4))
                    0: v = siext_pkg::SIGN_BIT;
                    1: v = siext_pkg::SIGN_BIT - 1;
                    2: v = siext_pkg::SIGN_BIT + 1;
                    3: v = siext_pkg::NONE_FOUND;
                    default: v = '0;
                endcase
            end
        endcase
        return v;
    endfunction

    // Offer one request beat at the falling edge, maybe after a few bubbles,
    // and hold it until the block takes it.
    task automatic send_beat(input logic [siext_pkg::OP_W-1:0]   opcode,
                             input logic [siext_pkg::DATA_W-1:0] x,
                             input logic [siext_pkg::DATA_W-1:0] y,
                             input logic [siext_pkg::DATA_W-1:0] z);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= opcode;
        req_ch.operand_x <= x;
        req_ch.operand_y <= y;
        req_ch.operand_z <= z;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic send_random_beats(input int count);
        logic [siext_pkg::OP_W-1:0]   opcode;
        logic [siext_pkg::DATA_W-1:0] x;
        logic [siext_pkg::DATA_W-1:0] y;
        int unsigned                  pick;
        repeat (count)
        begin
            // mostly defined opcodes, now and then a spare one
            if ($urandom_range(0, 99) < 92)
                pick = $urandom_range(siext_pkg::OP_SABS, siext_pkg::OP_UMSB);
            else
                pick = $urandom_range(OP_SPARE_LO, OP_SPARE_HI);
            opcode = pick[siext_pkg::OP_W-1:0];
            x = pick_operand();
            // equal operands hit the tie in min, max and clamp
            y = ($urandom_range(0, 9) == 0) ? x : pick_operand();
            send_beat(opcode, x, y, pick_operand());
        end
    endtask

    // Drop valid and wait until every expected result beat has come back.
    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Result side: bubble at random, or hold off for a long stretch on request.
    initial
    begin : rsp_side
        int holds_done;
        holds_done   = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_count != holds_done)
            begin
                holds_done = hold_count;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (!steady && $urandom_range(0, 99) < IDLE_PCT)
                rsp_ch.ready <= 1'b0;
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Watchdog: give up once neither channel has moved a beat for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        steady           = 1'b0;
        hold_count       = 0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = siext_pkg::OP_SABS;
        req_ch.operand_x = '0;
        req_ch.operand_y = '0;
        req_ch.operand_z = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed beats: field extremes, every opcode and the corner cases.
        // most negative wraps
        send_beat(siext_pkg::OP_SABS,   siext_pkg::SIGN_BIT,     '0, '0);
        send_beat(siext_pkg::OP_SABS,   siext_pkg::NONE_FOUND,   '0, '0);
        send_beat(siext_pkg::OP_SABS,   siext_pkg::SIGN_BIT - 1, '0, '0);
        // sign of zero
        send_beat(siext_pkg::OP_SSIGN,  '0,                      '0, '0);
        send_beat(siext_pkg::OP_SSIGN,  siext_pkg::SIGN_BIT,     '0, '0);
        send_beat(siext_pkg::OP_SSIGN,  siext_pkg::SIGN_BIT - 1, '0, '0);
        send_beat(siext_pkg::OP_UMIN,   '0, siext_pkg::NONE_FOUND, '0);
        send_beat(siext_pkg::OP_UMAX,   siext_pkg::NONE_FOUND, '0, '0);
        send_beat(siext_pkg::OP_SMIN,   siext_pkg::SIGN_BIT - 1, siext_pkg::SIGN_BIT, '0);
        send_beat(siext_pkg::OP_SMAX,   siext_pkg::SIGN_BIT, siext_pkg::SIGN_BIT - 1, '0);
        // crossed bounds
        send_beat(siext_pkg::OP_UCLAMP, 5, 10, 3);
        send_beat(siext_pkg::OP_UCLAMP, siext_pkg::NONE_FOUND, '0, siext_pkg::NONE_FOUND);
        // crossed, hi is -1
        send_beat(siext_pkg::OP_SCLAMP, '0, 1, siext_pkg::NONE_FOUND);
        send_beat(siext_pkg::OP_SCLAMP, siext_pkg::SIGN_BIT, siext_pkg::SIGN_BIT,
                  siext_pkg::SIGN_BIT - 1);
        // no bit found
        send_beat(siext_pkg::OP_LSB,    '0, '0, '0);
        send_beat(siext_pkg::OP_LSB,    siext_pkg::SIGN_BIT, '0, '0);
        send_beat(siext_pkg::OP_SMSB,   '0, '0, '0);
        send_beat(siext_pkg::OP_SMSB,   siext_pkg::NONE_FOUND, '0, '0);
        // one's complement count
        send_beat(siext_pkg::OP_SMSB,   siext_pkg::SIGN_BIT, '0, '0);
        send_beat(siext_pkg::OP_SMSB,   1, '0, '0);
        send_beat(siext_pkg::OP_UMSB,   '0, '0, '0);
        send_beat(siext_pkg::OP_UMSB,   siext_pkg::NONE_FOUND, siext_pkg::NONE_FOUND,
                  siext_pkg::NONE_FOUND);
        send_beat(OP_SPARE_LO, siext_pkg::NONE_FOUND, siext_pkg::NONE_FOUND,
                  siext_pkg::NONE_FOUND);
        send_beat(OP_SPARE_HI, siext_pkg::NONE_FOUND, siext_pkg::NONE_FOUND,
                  siext_pkg::NONE_FOUND);

        send_random_beats(300);

        // Stall the result side and keep offering, so the block fills up and
        // pushes back on its input.
        hold_count++;
        send_random_beats(60);
        send_random_beats(300);

        // Pause the request side until the block has emptied.
        wait_drained();

        // Back-to-back stretch with no bubbles on either side.
        steady = 1'b1;
        send_random_beats(400);
        steady = 1'b0;

        send_random_beats(590);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/siext_pkg.sv
rtl/siext_if.sv
rtl/siext_cmp.sv
rtl/siext_exec.sv
rtl/shader_integer_ext_alu_core.sv
rtl/shader_integer_ext_alu_core_chk.sv
verif/shader_integer_ext_alu_core_checker.sv
verif/shader_integer_ext_alu_core_tb.sv
